// File: src/pft_pkg.sv
// package for the page frame table with free frame fifo
// holds status codes and the controller state type; no dependencies
package pft_pkg;

  localparam int STATUS_BITS = 2;
  localparam int REFS_BITS   = 16;
  localparam int INDEX_BITS  = 6;
  localparam int COUNT_BITS  = 7;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_HIT     = 2'd0,
    ST_LOADED  = 2'd1,
    ST_NO_FREE = 2'd2,
    ST_RELEASE = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_ALLOC_RD,
    S_ALLOC_WR,
    S_HIT_WR,
    S_REL_RD,
    S_REL_WAIT,
    S_DONE
  } state_t;

endpackage

// File: src/page_frame_table_with_free_fifo.sv
// page frame table with free frame fifo, top level
// uses pft_pkg; frame memory and free queue memory live here
// a reference reads frames in order until a hit or the last frame, then takes the
// head of the free queue on a miss; a release reads every frame and writes back each
// owned one; page zero is answered without a scan
// throughput: one transaction at a time; the frame memory read port is the bottleneck
// reset: a clearing pass over every frame refills the free queue, busy stays high
// result appears for one cycle on done; the receiver cannot stall
module page_frame_table_with_free_fifo
  import pft_pkg::*;
#(
  parameter int NUM_FRAMES = 64,
  parameter int OWNER_BITS = 8,
  parameter int PAGE_BITS  = 12
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  operation,
  input  logic [OWNER_BITS-1:0] owner_id,
  input  logic [PAGE_BITS-1:0]  page_number,
  output logic                  done,
  output logic [1:0]            status,
  output logic [5:0]            frame_index,
  output logic [15:0]           reference_count,
  output logic [6:0]            free_count
);

  localparam int IW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CW = $clog2(NUM_FRAMES + 1);
  localparam int EW = 1 + OWNER_BITS + PAGE_BITS + REFS_BITS;
  localparam logic [REFS_BITS-1:0] REFS_MAX = '1;

  // frame memory: valid, owner, page, count; cleared by the reset pass
  logic [EW-1:0] frame_mem [NUM_FRAMES];
  logic [IW-1:0] queue_mem [NUM_FRAMES];

  logic          fm_we;
  logic [IW-1:0] fm_waddr;
  logic [EW-1:0] fm_wdata;
  logic [IW-1:0] fm_raddr;
  logic [EW-1:0] fm_rdata;
  logic          qm_we;
  logic [IW-1:0] qm_waddr;
  logic [IW-1:0] qm_wdata;
  logic [IW-1:0] qm_raddr;
  logic [IW-1:0] qm_rdata;

  always_ff @(posedge clk) begin
    if (fm_we) begin
      frame_mem[fm_waddr] <= fm_wdata;
    end
    fm_rdata <= frame_mem[fm_raddr];
  end

  always_ff @(posedge clk) begin
    if (qm_we) begin
      queue_mem[qm_waddr] <= qm_wdata;
    end
    qm_rdata <= queue_mem[qm_raddr];
  end

  // registers
  state_t                state, state_next;
  logic [IW-1:0]         idx, idx_next;
  logic [IW-1:0]         rd_idx, rd_idx_next;
  logic [IW-1:0]         hit_idx, hit_idx_next;
  logic [REFS_BITS-1:0]  hit_refs, hit_refs_next;
  logic [IW-1:0]         head, head_next;
  logic [IW-1:0]         tail, tail_next;
  logic [CW-1:0]         total, total_next;
  logic [OWNER_BITS-1:0] owner_r;
  logic [PAGE_BITS-1:0]  page_r;
  status_t               res_status, res_status_next;
  logic [IW-1:0]         res_index, res_index_next;
  logic [REFS_BITS-1:0]  res_refs, res_refs_next;
  logic                  done_next;

  // fields of the frame just read
  logic                  e_valid;
  logic [OWNER_BITS-1:0] e_owner;
  logic [PAGE_BITS-1:0]  e_page;
  logic [REFS_BITS-1:0]  e_refs;
  assign {e_valid, e_owner, e_page, e_refs} = fm_rdata;

  logic owner_match;
  assign owner_match = e_valid && (e_owner == owner_r);

  logic last_idx;
  assign last_idx = (idx == IW'(NUM_FRAMES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      idx   <= '0;
      head  <= '0;
      tail  <= '0;
      total <= CW'(NUM_FRAMES);
      done  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      head  <= head_next;
      tail  <= tail_next;
      total <= total_next;
      done  <= done_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx     <= rd_idx_next;
    hit_idx    <= hit_idx_next;
    hit_refs   <= hit_refs_next;
    res_status <= res_status_next;
    res_index  <= res_index_next;
    res_refs   <= res_refs_next;
    if (start && !busy) begin
      owner_r <= owner_id;
      page_r  <= page_number;
    end
  end

  // controller
  always_comb begin
    state_next      = state;
    idx_next        = idx;
    rd_idx_next     = rd_idx;
    hit_idx_next    = hit_idx;
    hit_refs_next   = hit_refs;
    head_next       = head;
    tail_next       = tail;
    total_next      = total;
    res_status_next = res_status;
    res_index_next  = res_index;
    res_refs_next   = res_refs;
    done_next       = 1'b0;
    fm_we           = 1'b0;
    fm_waddr        = idx;
    fm_wdata        = '0;
    fm_raddr        = idx;
    qm_we           = 1'b0;
    qm_waddr        = idx;
    qm_wdata        = idx;
    qm_raddr        = head;
    case (state)
      S_CLEAR: begin
        fm_we = 1'b1;
        qm_we = 1'b1;
        idx_next = idx + 1'b1;
        if (last_idx) begin
          idx_next   = '0;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          idx_next = '0;
          if (operation) begin
            state_next = S_REL_RD;
          end else if (page_number == '0) begin
            res_status_next = ST_HIT;
            res_index_next  = '0;
            res_refs_next   = '0;
            state_next      = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      // issue read of frame idx, then check the registered data in S_SCAN_WAIT
      S_SCAN: begin
        fm_raddr    = idx;
        rd_idx_next = idx;
        state_next  = S_SCAN_WAIT;
      end
      S_SCAN_WAIT: begin
        if (owner_match && e_page == page_r) begin
          hit_idx_next  = rd_idx;
          hit_refs_next = (e_refs == REFS_MAX) ? e_refs : e_refs + 1'b1;
          state_next    = S_HIT_WR;
        end else if (rd_idx == IW'(NUM_FRAMES - 1)) begin
          if (total == '0) begin
            res_status_next = ST_NO_FREE;
            res_index_next  = '0;
            res_refs_next   = '0;
            state_next      = S_DONE;
          end else begin
            qm_raddr   = head;
            state_next = S_ALLOC_RD;
          end
        end else begin
          idx_next   = idx + 1'b1;
          fm_raddr   = idx + 1'b1;
          rd_idx_next = idx + 1'b1;
        end
      end
      S_HIT_WR: begin
        fm_we           = 1'b1;
        fm_waddr        = hit_idx;
        fm_wdata        = {1'b1, owner_r, page_r, hit_refs};
        res_status_next = ST_HIT;
        res_index_next  = hit_idx;
        res_refs_next   = hit_refs;
        state_next      = S_DONE;
      end
      S_ALLOC_RD: begin
        state_next = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        fm_we           = 1'b1;
        fm_waddr        = qm_rdata;
        fm_wdata        = {1'b1, owner_r, page_r, REFS_BITS'(1)};
        head_next       = (head == IW'(NUM_FRAMES - 1)) ? '0 : head + 1'b1;
        total_next      = total - 1'b1;
        res_status_next = ST_LOADED;
        res_index_next  = qm_rdata;
        res_refs_next   = REFS_BITS'(1);
        state_next      = S_DONE;
      end
      // release: read frame, then invalidate it if owned and queue it if the queue is not full
      S_REL_RD: begin
        fm_raddr    = idx;
        rd_idx_next = idx;
        state_next  = S_REL_WAIT;
      end
      S_REL_WAIT: begin
        if (owner_match) begin
          fm_we    = 1'b1;
          fm_waddr = rd_idx;
          fm_wdata = {1'b0, e_owner, e_page, e_refs};
          if (total != CW'(NUM_FRAMES)) begin
            qm_we      = 1'b1;
            qm_waddr   = tail;
            qm_wdata   = rd_idx;
            tail_next  = (tail == IW'(NUM_FRAMES - 1)) ? '0 : tail + 1'b1;
            total_next = total + 1'b1;
          end
        end
        if (rd_idx == IW'(NUM_FRAMES - 1)) begin
          res_status_next = ST_RELEASE;
          res_index_next  = '0;
          res_refs_next   = '0;
          state_next      = S_DONE;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = S_REL_RD;
        end
      end
      S_DONE: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs
  assign busy            = (state != S_IDLE);
  assign status          = res_status;
  assign frame_index     = 6'(res_index);
  assign reference_count = res_refs;
  assign free_count      = 7'(total);

endmodule

// File: src/pft_checker.sv
// port-level checker for the page frame table
// uses pft_pkg status codes; bound to page_frame_table_with_free_fifo
module pft_checker
  import pft_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [1:0] status,
  input logic [5:0] frame_index,
  input logic [15:0] reference_count,
  input logic [6:0] free_count
);

  // a result never shows while idle before it
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without transaction");

  // accepted transaction makes block busy
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("not busy after start");

  // release and no-free results carry no frame
  a_norefs: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_RELEASE || status == ST_NO_FREE)) |->
      (reference_count == '0 && frame_index == '0)) else $error("stray frame");

  // a load gives a count of one
  a_load: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_LOADED) |-> (reference_count == 16'd1))
    else $error("load count");

  // free count only moves while busy
  a_free_stable: assert property (@(posedge clk) disable iff (rst)
    (!busy && $past(!busy) && !$past(rst)) |-> $stable(free_count))
    else $error("free count moved when idle");

endmodule

bind page_frame_table_with_free_fifo pft_checker u_pft_checker (.*);

// File: tb/sv/tb_top.sv
// testbench for page_frame_table_with_free_fifo: directed table then random traffic
// depends on pft_pkg and the top level rtl; predicts each transaction's result in-line
module tb_top;
  import pft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = 64;
  localparam int REFS_MAX = 65535;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 1570;

  localparam logic OP_REF = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = 1'b0;
  logic [7:0] owner_id = '0;
  logic [11:0] page_number = '0;
  logic busy, done;
  logic [1:0] status;
  logic [5:0] frame_index;
  logic [15:0] reference_count;
  logic [6:0] free_count;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] index;
    logic [15:0] refs;
    logic [6:0] free;
  } lookup_result_t;

  typedef struct {
    logic op;
    logic [7:0] owner;
    logic [11:0] page;
    bit known;
    lookup_result_t res;
  } stim_row_t;

  // shadow frame table
  bit fr_valid [FRAMES];
  logic [7:0] fr_owner [FRAMES];
  logic [11:0] fr_page [FRAMES];
  int unsigned fr_refs [FRAMES];
  int free_list[$];

  lookup_result_t pending_results[$];
  int mismatches = 0;
  int idle_cycles = 0;

  page_frame_table_with_free_fifo u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .operation(operation),
    .owner_id(owner_id), .page_number(page_number), .done(done), .status(status),
    .frame_index(frame_index), .reference_count(reference_count),
    .free_count(free_count)
  );

  always #2 clk = ~clk;

  // predict one transaction and update the shadow table
  function automatic lookup_result_t predict_lookup(logic op, logic [7:0] own,
                                                    logic [11:0] pg);
    lookup_result_t r;
    int hit;
    int f;
    r = '0;
    hit = -1;
    if (op == OP_RELEASE) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (fr_valid[i] && fr_owner[i] == own) begin
          fr_valid[i] = 0;
          if (free_list.size() < FRAMES) free_list.push_back(i);
        end
      end
      r.status = ST_RELEASE;
    end else if (pg == 0) begin
      r.status = ST_HIT;
    end else begin
      for (int i = FRAMES - 1; i >= 0; i--)
        if (fr_valid[i] && fr_owner[i] == own && fr_page[i] == pg) hit = i;
      if (hit >= 0) begin
        if (fr_refs[hit] < REFS_MAX) fr_refs[hit]++;
        r.status = ST_HIT;
        r.index = 6'(hit);
        r.refs = 16'(fr_refs[hit]);
      end else if (free_list.size() == 0) begin
        r.status = ST_NO_FREE;
      end else begin
        f = free_list.pop_front();
        fr_valid[f] = 1;
        fr_owner[f] = own;
        fr_page[f] = pg;
        fr_refs[f] = 1;
        r.status = ST_LOADED;
        r.index = 6'(f);
        r.refs = 16'd1;
      end
    end
    r.free = 7'(free_list.size());
    return r;
  endfunction

  // drive one transaction, wait for acceptance, queue its expectation
  task automatic issue_request(logic op, logic [7:0] own, logic [11:0] pg, bit known,
                               lookup_result_t typed);
    lookup_result_t p;
    @(posedge clk);
    start <= 1'b1;
    operation <= op;
    owner_id <= own;
    page_number <= pg;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 1'b0;
    p = predict_lookup(op, own, pg);
    pending_results.push_back(known ? typed : p);
  endtask

  // result checker and watchdog
  always @(posedge clk) begin
    lookup_result_t e;
    lookup_result_t got;
    if (!rst) begin
      idle_cycles <= (done || (start && !busy)) ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout waiting for activity");
        $display("== FAIL ==");
        $finish;
      end
      if (done) begin
        got = '{status, frame_index, reference_count, free_count};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %h", got);
        end else begin
          e = pending_results.pop_front();
          if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: exp st=%0d idx=%0d refs=%0d free=%0d",
                        " got st=%0d idx=%0d refs=%0d free=%0d"},
                       e.status, e.index, e.refs, e.free,
                       got.status, got.index, got.refs, got.free);
          end
        end
      end
    end
  end

  // a page for random traffic: mostly a small working set, sometimes page zero or anything
  function automatic logic [11:0] pick_page();
    case ($urandom_range(0, 9))
      0: return 12'h000;
      1, 2: return 12'($urandom());
      default: return 12'($urandom_range(1, 24));
    endcase
  endfunction

  initial begin
    stim_row_t rows[$];
    int gap;
    int burst;
    logic [7:0] own;
    for (int i = 0; i < FRAMES; i++) begin
      fr_valid[i] = 0;
      fr_owner[i] = '0;
      fr_page[i] = '0;
      fr_refs[i] = 0;
      free_list.push_back(i);
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows; typed results only where obvious
    rows.push_back('{OP_REF, 8'h00, 12'h000, 1, '{ST_HIT, 6'd0, 16'd0, 7'd64}});
    rows.push_back('{OP_RELEASE, 8'hff, 12'hfff, 1, '{ST_RELEASE, 6'd0, 16'd0, 7'd64}});
    rows.push_back('{OP_REF, 8'hff, 12'hfff, 1, '{ST_LOADED, 6'd0, 16'd1, 7'd63}});
    rows.push_back('{OP_REF, 8'hff, 12'hfff, 1, '{ST_HIT, 6'd0, 16'd2, 7'd63}});
    rows.push_back('{OP_REF, 8'h00, 12'hfff, 1, '{ST_LOADED, 6'd1, 16'd1, 7'd62}});
    rows.push_back('{OP_REF, 8'haa, 12'h555, 0, '0});
    rows.push_back('{OP_REF, 8'h55, 12'haaa, 0, '0});
    rows.push_back('{OP_REF, 8'hff, 12'h000, 1, '{ST_HIT, 6'd0, 16'd0, 7'd60}});
    rows.push_back('{OP_RELEASE, 8'hff, 12'h000, 0, '0});
    rows.push_back('{OP_REF, 8'h01, 12'h001, 0, '0});
    rows.push_back('{OP_RELEASE, 8'h00, 12'h000, 0, '0});
    foreach (rows[k]) issue_request(rows[k].op, rows[k].owner, rows[k].page,
                                    rows[k].known, rows[k].res);

    // fill every free frame, then more misses on an empty queue, then free them
    for (int i = 0; i < 66; i++)
      issue_request(OP_REF, 8'h07, 12'(100 + i), 0, '0);
    issue_request(OP_RELEASE, 8'h07, 12'h0, 0, '0);
    issue_request(OP_RELEASE, 8'haa, 12'h0, 0, '0);
    issue_request(OP_RELEASE, 8'h55, 12'h0, 0, '0);
    issue_request(OP_RELEASE, 8'h01, 12'h0, 0, '0);

    // one load, then release it
    issue_request(OP_REF, 8'h33, 12'h123, 0, '0);
    issue_request(OP_RELEASE, 8'h33, 12'h0, 0, '0);

    // random traffic in bursts; few owners so hits, misses and releases mix
    for (int n = 0; n < RANDOM_ITEMS; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst && n < RANDOM_ITEMS; b++, n++) begin
        own = ($urandom_range(0, 7) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 5));
        if ($urandom_range(0, 24) == 0)
          issue_request(OP_RELEASE, own, 12'($urandom()), 0, '0);
        else
          issue_request(OP_REF, own, pick_page(), 0, '0);
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
    end

    while (pending_results.size() != 0) @(posedge clk);
    repeat (FRAMES + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
